@@ src/tdwq_pkg.sv @@
// Shared types and constants for the tick delay wake-up queue.
`default_nettype none
package tdwq_pkg;

	localparam int QUEUE_SLOTS_DEF    = 32;
	localparam int CLIENT_ID_BITS_DEF = 8;
	localparam int TIME_W             = 31;
	localparam int REPLY_ID_W         = 8;
	localparam logic [TIME_W-1:0] COUNT_MAX = {TIME_W{1'b1}};

	// Request codes
	typedef enum logic [1:0] {
		ACT_TIME  = 2'd0,
		ACT_DELAY = 2'd1,
		ACT_UNTIL = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	// Reply codes
	typedef enum logic [2:0] {
		ST_TIME = 3'd0,
		ST_WAKE = 3'd1,
		ST_ACK  = 3'd2,
		ST_NEG  = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_CHECK,
		S_RELEASE
	} state_t;

	// Operation broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_op_t;

endpackage
`default_nettype wire

@@ src/tdwq_cell.sv @@
// One slot of the sorted wake-up chain: holds an entry, shifts with its neighbors.
`default_nettype none
module tdwq_cell #(
	parameter int ID_W = tdwq_pkg::CLIENT_ID_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  tdwq_pkg::cell_op_t       op,
	input  wire  [tdwq_pkg::TIME_W-1:0]    key,
	input  wire  [ID_W-1:0]                new_id,
	input  wire                            prev_keep,
	input  wire                            prev_valid,
	input  wire  [tdwq_pkg::TIME_W-1:0]    prev_time,
	input  wire  [ID_W-1:0]                prev_id,
	input  wire                            next_valid,
	input  wire  [tdwq_pkg::TIME_W-1:0]    next_time,
	input  wire  [ID_W-1:0]                next_id,
	output logic                           keep,
	output logic                           valid,
	output logic [tdwq_pkg::TIME_W-1:0]    wake_time,
	output logic [ID_W-1:0]                waiter_id
);
	import tdwq_pkg::*;

	logic              valid_q;
	logic [TIME_W-1:0] time_q;
	logic [ID_W-1:0]   id_q;

	// Entry stays put on insert when it wakes strictly before the new one
	assign keep      = valid_q && (time_q < key);
	assign valid     = valid_q;
	assign wake_time = time_q;
	assign waiter_id = id_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.pop) begin
			valid_q <= next_valid;
		end else if (op.insert && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (op.pop) begin
			time_q <= next_time;
			id_q   <= next_id;
		end else if (op.insert && !keep) begin
			if (prev_keep) begin
				time_q <= key;
				id_q   <= new_id;
			end else begin
				time_q <= prev_time;
				id_q   <= prev_id;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/tick_delay_wakeup_queue.sv @@
// Top level: tick counter, request controller and the chain of queue cells.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+---------------------------------
//  request | action, requester, amount                | taken when start && !busy
//  reply   | reply_to, status, time_value, last       | each beat valid for one cycle, no stall
//
// Time read, negative delay: the reply is registered from S_CALC.
// Delays: S_CALC, then S_CHECK registers the reply or does a silent insert;
// on insert all cells compare against the new wake time in parallel.
// Tick: acknowledge registered from S_CALC, then in S_RELEASE one wake-up per cycle,
// one cell shift per released waiter.
// busy drops while the last reply beat is on the ports, so the next request beat
// lands with it at the earliest; reset empties the queue at once.
`default_nettype none
module tick_delay_wakeup_queue #(
	parameter int QUEUE_SLOTS    = tdwq_pkg::QUEUE_SLOTS_DEF,
	parameter int CLIENT_ID_BITS = tdwq_pkg::CLIENT_ID_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [1:0]                         action,
	input  wire  [7:0]                         requester,
	input  wire  signed [31:0]                 amount,
	output logic                               reply_valid,
	output logic [tdwq_pkg::REPLY_ID_W-1:0]    reply_to,
	output logic [2:0]                         status,
	output logic [tdwq_pkg::TIME_W-1:0]        time_value,
	output logic                               last
);
	import tdwq_pkg::*;

	localparam int ID_W     = CLIENT_ID_BITS;
	localparam int NEXT_IDX = (QUEUE_SLOTS > 1) ? 1 : 0;

	state_t            state_q, state_d;
	action_t           act_q;
	logic [ID_W-1:0]   who_q;
	logic [31:0]       amount_q;
	logic [TIME_W-1:0] when_q;
	logic [TIME_W-1:0] count_q;

	logic              reply_valid_q;
	logic [REPLY_ID_W-1:0] reply_to_q;
	status_t           status_q;
	logic [TIME_W-1:0] time_value_q;
	logic              last_q;

	// Chain taps
	logic              cell_valid [QUEUE_SLOTS];
	logic [TIME_W-1:0] cell_time  [QUEUE_SLOTS];
	logic [ID_W-1:0]   cell_id    [QUEUE_SLOTS];
	logic              cell_keep  [QUEUE_SLOTS];
	cell_op_t          op;

	// Requester kept to the client id width
	logic [ID_W+7:0]   req_ext;
	logic [ID_W-1:0]   req_id;
	assign req_ext = {{ID_W{1'b0}}, requester};
	assign req_id  = req_ext[ID_W-1:0];

	// Arithmetic shared by the controller
	logic [TIME_W:0]   rel_sum;
	logic [TIME_W-1:0] rel_when;
	logic [TIME_W-1:0] count_inc;
	logic              amount_neg;
	logic              head_due_inc;
	logic              head_due;
	logic              second_due;
	logic              queue_full;
	logic              when_passed;

	assign amount_neg   = amount_q[31];
	assign rel_sum      = {1'b0, count_q} + {1'b0, amount_q[TIME_W-1:0]};
	assign rel_when     = rel_sum[TIME_W] ? COUNT_MAX : rel_sum[TIME_W-1:0];
	assign count_inc    = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
	assign head_due_inc = cell_valid[0] && (cell_time[0] <= count_inc);
	assign head_due     = cell_valid[0] && (cell_time[0] <= count_q);
	assign second_due   = (QUEUE_SLOTS > 1) && cell_valid[NEXT_IDX]
	                      && (cell_time[NEXT_IDX] <= count_q);
	assign queue_full   = cell_valid[QUEUE_SLOTS-1];
	assign when_passed  = when_q <= count_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CALC;
			end
			S_CALC: begin
				unique case (act_q)
					ACT_TIME:  state_d = S_IDLE;
					ACT_DELAY: state_d = amount_neg ? S_IDLE : S_CHECK;
					ACT_UNTIL: state_d = amount_neg ? S_IDLE : S_CHECK;
					ACT_TICK:  state_d = head_due_inc ? S_RELEASE : S_IDLE;
					default:   state_d = S_IDLE;
				endcase
			end
			S_CHECK: begin
				state_d = S_IDLE;
			end
			S_RELEASE: begin
				state_d = second_due ? S_RELEASE : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the controller: reply beat and chain operation
	logic              emit;
	logic [ID_W-1:0]   emit_id;
	status_t           emit_status;
	logic [TIME_W-1:0] emit_time;
	logic              emit_last;
	logic              when_load;
	logic [TIME_W-1:0] when_d;
	logic              count_load;

	always_comb begin
		emit        = 1'b0;
		emit_id     = who_q;
		emit_status = ST_TIME;
		emit_time   = count_q;
		emit_last   = 1'b1;
		when_load   = 1'b0;
		when_d      = amount_q[TIME_W-1:0];
		count_load  = 1'b0;
		op          = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_CALC: begin
				unique case (act_q)
					ACT_TIME: begin
						emit = 1'b1;
					end
					ACT_DELAY: begin
						if (amount_neg) begin
							emit        = 1'b1;
							emit_status = ST_NEG;
							emit_time   = '0;
						end else begin
							when_load = 1'b1;
							when_d    = rel_when;
						end
					end
					ACT_UNTIL: begin
						if (amount_neg) begin
							emit        = 1'b1;
							emit_status = ST_WAKE;
						end else begin
							when_load = 1'b1;
						end
					end
					ACT_TICK: begin
						emit        = 1'b1;
						emit_status = ST_ACK;
						emit_last   = !head_due_inc;
						count_load  = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_CHECK: begin
				if (when_passed) begin
					emit        = 1'b1;
					emit_status = ST_WAKE;
				end else if (queue_full) begin
					emit        = 1'b1;
					emit_status = ST_FULL;
					emit_time   = '0;
				end else begin
					op.insert = 1'b1;
				end
			end
			S_RELEASE: begin
				emit        = head_due;
				emit_id     = cell_id[0];
				emit_status = ST_WAKE;
				emit_last   = !second_due;
				op.pop      = head_due;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			reply_valid_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			reply_valid_q <= emit;
			if (count_load) count_q <= count_inc;
		end
	end

	// Request and reply payload
	logic [ID_W+7:0] emit_id_ext;
	assign emit_id_ext = {8'd0, emit_id};

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q    <= action_t'(action);
			who_q    <= req_id;
			amount_q <= amount;
		end
		if (when_load) when_q <= when_d;
		if (emit) begin
			reply_to_q   <= emit_id_ext[REPLY_ID_W-1:0];
			status_q     <= emit_status;
			time_value_q <= emit_time;
			last_q       <= emit_last;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign reply_valid = reply_valid_q;
	assign reply_to    = reply_to_q;
	assign status      = status_q;
	assign time_value  = time_value_q;
	assign last        = last_q;

	// Sorted chain, head at slot 0
	for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_cell
		logic              p_keep;
		logic              p_valid;
		logic [TIME_W-1:0] p_time;
		logic [ID_W-1:0]   p_id;
		logic              n_valid;
		logic [TIME_W-1:0] n_time;
		logic [ID_W-1:0]   n_id;

		if (i == 0) begin : g_head
			assign p_keep  = 1'b1;
			assign p_valid = 1'b0;
			assign p_time  = '0;
			assign p_id    = '0;
		end else begin : g_body
			assign p_keep  = cell_keep[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_time  = cell_time[i-1];
			assign p_id    = cell_id[i-1];
		end

		if (i == QUEUE_SLOTS - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_time  = '0;
			assign n_id    = '0;
		end else begin : g_link
			assign n_valid = cell_valid[i+1];
			assign n_time  = cell_time[i+1];
			assign n_id    = cell_id[i+1];
		end

		tdwq_cell #(
			.ID_W(ID_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.key       (when_q),
			.new_id    (who_q),
			.prev_keep (p_keep),
			.prev_valid(p_valid),
			.prev_time (p_time),
			.prev_id   (p_id),
			.next_valid(n_valid),
			.next_time (n_time),
			.next_id   (n_id),
			.keep      (cell_keep[i]),
			.valid     (cell_valid[i]),
			.wake_time (cell_time[i]),
			.waiter_id (cell_id[i])
		);
	end

endmodule
`default_nettype wire

@@ sim/tb_tick_delay_wakeup_queue.sv @@
// Self-checking testbench for the tick delay wake-up queue: predictor, scoreboard and stimulus.
`timescale 1ns / 100ps
module tb_tick_delay_wakeup_queue;
	import tdwq_pkg::*;

	localparam int RANDOM_ITEMS = 350;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = QUEUE_SLOTS_DEF + 8;

	// One reply beat as the block should send it
	typedef struct {
		logic [REPLY_ID_W-1:0] dest;
		status_t               st;
		logic [TIME_W-1:0]     tv;
		logic                  last_beat;
	} reply_beat_t;

	// Timer queue predictor plus the list of replies still owed by the block
	class reply_scoreboard;
		logic [TIME_W-1:0]     tick_count;
		logic [TIME_W-1:0]     wake_at [QUEUE_SLOTS_DEF];
		logic [REPLY_ID_W-1:0] sleeper [QUEUE_SLOTS_DEF];
		int                    occupied;
		reply_beat_t           owed[$];
		int                    errors;

		function new();
			tick_count = '0;
			occupied   = 0;
			errors     = 0;
		endfunction

		function void owe(logic [REPLY_ID_W-1:0] dest, status_t st, logic [TIME_W-1:0] tv);
			reply_beat_t b;
			b.dest      = dest;
			b.st        = st;
			b.tv        = tv;
			b.last_beat = 1'b0;
			owed.push_back(b);
		endfunction

		// Immediate wake, full error, or sorted insert ahead of equal times
		function void park_waiter(logic [REPLY_ID_W-1:0] who, logic [TIME_W-1:0] wake_tick);
			int pos;
			if (wake_tick <= tick_count) begin
				owe(who, ST_WAKE, tick_count);
			end else if (occupied >= QUEUE_SLOTS_DEF) begin
				owe(who, ST_FULL, '0);
			end else begin
				pos = 0;
				while (pos < occupied && wake_at[pos] < wake_tick)
					pos++;
				for (int i = occupied; i > pos; i--) begin
					wake_at[i] = wake_at[i-1];
					sleeper[i] = sleeper[i-1];
				end
				wake_at[pos] = wake_tick;
				sleeper[pos] = who;
				occupied++;
			end
		endfunction

		// Accepted request beat: advance the model and queue up its replies
		function void note_request(action_t act, logic [7:0] who, logic signed [31:0] amt);
			logic [32:0] sum;
			int          n_before;
			int          released;
			reply_beat_t b;
			n_before = owed.size();
			case (act)
				ACT_TIME: begin
					owe(who, ST_TIME, tick_count);
				end
				ACT_DELAY: begin
					if (amt[31]) begin
						owe(who, ST_NEG, '0);
					end else begin
						sum = {2'b00, tick_count} + {1'b0, amt};
						if (sum > {2'b00, COUNT_MAX})
							sum = {2'b00, COUNT_MAX};
						park_waiter(who, sum[TIME_W-1:0]);
					end
				end
				ACT_UNTIL: begin
					if (amt[31])
						owe(who, ST_WAKE, tick_count);
					else
						park_waiter(who, amt[TIME_W-1:0]);
				end
				default: begin
					owe(who, ST_ACK, tick_count);
					if (tick_count != COUNT_MAX)
						tick_count++;
					released = 0;
					while (released < occupied && wake_at[released] <= tick_count) begin
						owe(sleeper[released], ST_WAKE, tick_count);
						released++;
					end
					for (int i = released; i < occupied; i++) begin
						wake_at[i-released] = wake_at[i];
						sleeper[i-released] = sleeper[i];
					end
					occupied -= released;
				end
			endcase
			// flag the final beat of this request
			if (owed.size() > n_before) begin
				b = owed.pop_back();
				b.last_beat = 1'b1;
				owed.push_back(b);
			end
		endfunction

		// Reply beat seen on the ports: compare with the oldest owed reply
		function void check_reply(logic [7:0] dest, logic [2:0] st, logic [TIME_W-1:0] tv,
				logic lst);
			reply_beat_t e;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply: expected none, actual to %0d status %0d time %0d",
					$time, dest, st, tv);
				return;
			end
			e = owed.pop_front();
			if (dest !== e.dest) begin
				errors++;
				$display("%0t: reply_to mismatch: expected %0d actual %0d", $time, e.dest, dest);
			end
			if (st !== e.st) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d", $time, e.st, st);
			end
			if (tv !== e.tv) begin
				errors++;
				$display("%0t: time_value mismatch: expected %0d actual %0d", $time, e.tv, tv);
			end
			if (lst !== e.last_beat) begin
				errors++;
				$display("%0t: last mismatch: expected %0d actual %0d", $time, e.last_beat, lst);
			end
		endfunction

		function void flag_missing();
			reply_beat_t e;
			while (owed.size() != 0) begin
				e = owed.pop_front();
				errors++;
				$display("%0t: missing reply: expected to %0d status %0d time %0d, actual none",
					$time, e.dest, e.st, e.tv);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	action_t                   action;
	logic [7:0]                requester;
	logic signed [31:0]        amount;
	logic                      reply_valid;
	logic [REPLY_ID_W-1:0]     reply_to;
	logic [2:0]                status;
	logic [TIME_W-1:0]         time_value;
	logic                      last;

	reply_scoreboard sb;
	int              cycles;
	int              items_sent;
	int              quiet_left;

	tick_delay_wakeup_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.requester   (requester),
		.amount      (amount),
		.reply_valid (reply_valid),
		.reply_to    (reply_to),
		.status      (status),
		.time_value  (time_value),
		.last        (last)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Reply monitor
	always @(posedge clk) begin
		if (arst_n && reply_valid)
			sb.check_reply(reply_to, status, time_value, last);
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Drive one request beat after a random gap; returns just after the next falling edge
	task automatic send_request(action_t act, logic [7:0] who, logic signed [31:0] amt);
		int gap;
		gap = (quiet_left > 0) ? 0 : $urandom_range(0, 18);
		if (quiet_left > 0)
			quiet_left--;
		else if ($urandom_range(0, 19) == 0)
			quiet_left = $urandom_range(10, 30);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action    <= act;
		requester <= who;
		amount    <= amt;
		start     <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(act, who, amt);
		items_sent++;
		@(negedge clk);
	endtask

	// Fill the queue past capacity with near wake times, then tick them out
	task automatic fill_and_drain();
		logic signed [31:0] amt;
		repeat (QUEUE_SLOTS_DEF + 2) begin
			amt = int'(sb.tick_count) + int'($urandom_range(1, 4));
			send_request(ACT_UNTIL, 8'($urandom_range(0, 255)), amt);
		end
		repeat (5)
			send_request(ACT_TICK, 8'($urandom_range(0, 255)), $urandom);
	endtask

	// One random request, mostly well-formed delays near the current count
	task automatic random_item();
		action_t            act;
		logic [7:0]         who;
		logic signed [31:0] amt;
		int                 pick;
		int                 m;
		who  = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		m    = $urandom_range(0, 99);
		amt  = $urandom;
		if (pick < 15)
			act = ACT_TIME;
		else if (pick < 45)
			act = ACT_DELAY;
		else if (pick < 70)
			act = ACT_UNTIL;
		else
			act = ACT_TICK;
		if (act == ACT_DELAY && m >= 4) begin
			if (m < 8) begin
				case ($urandom_range(0, 3))
					0: amt = 32'sh8000_0000;
					1: amt = -32'sd1;
					2: amt = 32'sd0;
					default: amt = 32'sd1;
				endcase
			end else begin
				amt = $urandom_range(0, 24);
			end
		end else if (act == ACT_UNTIL && m >= 4) begin
			if (m < 8) begin
				case ($urandom_range(0, 3))
					0: amt = 32'sh8000_0000;
					1: amt = -32'sd1;
					2: amt = 32'sd0;
					default: amt = int'(sb.tick_count);
				endcase
			end else begin
				amt = int'(sb.tick_count) + int'($urandom_range(0, 26)) - 3;
			end
		end
		send_request(act, who, amt);
	endtask

	initial begin
		sb         = new();
		cycles     = 0;
		items_sent = 0;
		quiet_left = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = ACT_TIME;
		requester  = '0;
		amount     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: error paths, immediate wakes, saturation, tie order
		send_request(ACT_TIME,  8'd0,   32'sd0);
		send_request(ACT_DELAY, 8'd255, 32'sh8000_0000);
		send_request(ACT_DELAY, 8'd17,  -32'sd1);
		send_request(ACT_UNTIL, 8'd18,  32'sh8000_0000);
		send_request(ACT_UNTIL, 8'd19,  32'sd0);
		send_request(ACT_DELAY, 8'd20,  32'sd0);
		send_request(ACT_TICK,  8'hAA,  32'sh7FFF_FFFF);
		send_request(ACT_DELAY, 8'd21,  32'sh7FFF_FFFF);
		send_request(ACT_UNTIL, 8'd22,  32'sh7FFF_FFFF);
		send_request(ACT_UNTIL, 8'd1,   32'sd3);
		send_request(ACT_UNTIL, 8'd2,   32'sd3);
		send_request(ACT_UNTIL, 8'd3,   32'sd3);
		send_request(ACT_DELAY, 8'd4,   32'sd2);
		send_request(ACT_DELAY, 8'd5,   32'sd1);
		send_request(ACT_TICK,  8'd6,   -32'sd1);
		send_request(ACT_TIME,  8'd7,   32'sh5555_5555);
		send_request(ACT_TICK,  8'd8,   32'shAAAA_AAAA);
		send_request(ACT_UNTIL, 8'd9,   32'sd3);
		send_request(ACT_UNTIL, 8'd10,  32'sd4);
		send_request(ACT_TICK,  8'd0,   32'sd0);
		send_request(ACT_TIME,  8'h55,  32'sd0);

		// random traffic with occasional queue-full bursts
		items_sent = 0;
		fill_and_drain();
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 2)
				fill_and_drain();
			else
				random_item();
		end
		start <= 1'b0;

		// drain
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		sb.flag_missing();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
